// ===== design/utc_lt_pkg.sv =====
// Shared types, constants and calendar helpers for the UTC to local time converter.
package utc_lt_pkg;

    localparam int YearW    = 14;
    localparam int MonthW   = 4;
    localparam int DayW     = 5;
    localparam int WeekdayW = 3;
    localparam int HourW    = 5;
    localparam int MinuteW  = 6;
    localparam int SecondW  = 6;
    localparam int OffsetW  = 11;
    localparam int OffHourW = 6;
    localparam int OffMinW  = 7;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 32;

    localparam logic [7:0] MinPerHour    = 8'd60;
    localparam logic [7:0] HoursPerDay   = 8'd24;
    localparam logic [2:0] DaysPerWeek   = 3'd7;
    localparam logic [4:0] MonthsPerYear = 5'd12;

    // register index codes (word index on the config port)
    localparam logic RegOffsetIdx = 1'b0;

    // 25 is odd, so divisibility shows as (y * inverse mod 2^14) <= floor((2^14-1)/25)
    localparam logic [YearW-1:0] Inv25    = 14'd7209;
    localparam logic [YearW-1:0] Div25Max = 14'd655;

    localparam logic [DayW-1:0] MonthLen [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [YearW-1:0]    utc_year;
        logic [MonthW-1:0]   utc_month;
        logic [DayW-1:0]     utc_day;
        logic [WeekdayW-1:0] utc_weekday;
        logic [HourW-1:0]    utc_hour;
        logic [MinuteW-1:0]  utc_minute;
        logic [SecondW-1:0]  utc_second;
    } utc_time_t;

    typedef struct packed {
        logic [YearW-1:0]    local_year;
        logic [MonthW-1:0]   local_month;
        logic [DayW-1:0]     local_day;
        logic [WeekdayW-1:0] local_weekday;
        logic [HourW-1:0]    local_hour;
        logic [MinuteW-1:0]  local_minute;
        logic [SecondW-1:0]  local_second;
    } local_time_t;

    // offset split into hour and minute parts, both carrying the offset's sign
    typedef struct packed {
        logic [OffHourW-1:0] off_hour;
        logic [OffMinW-1:0]  off_min;
    } offset_split_t;

    function automatic logic is_leap(input logic [YearW-1:0] y);
        logic [YearW-1:0] p;
        logic             div25;
        p     = y * Inv25;
        div25 = (p <= Div25Max);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    // months outside 1..12 count as 31 days
    function automatic logic [DayW-1:0] days_in_month(input logic [MonthW-1:0] mon,
                                                      input logic leap);
        logic [MonthW-1:0] idx;
        idx = mon - 4'd1;
        if (mon == 4'd0 || {1'b0, mon} > MonthsPerYear)
            return 5'd31;
        if (mon == 4'd2 && leap)
            return 5'd29;
        return MonthLen[idx];
    endfunction

endpackage

// ===== design/utc_lt_cfg.sv =====
// Configuration register file: zone offset register and its hour/minute split.
module utc_lt_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [utc_lt_pkg::CfgAddrW-1:0]    paddr,
    input  logic [utc_lt_pkg::CfgDataW-1:0]    pwdata,
    output logic [utc_lt_pkg::CfgDataW-1:0]    prdata,
    output logic                               pready,
    output utc_lt_pkg::offset_split_t          split
);
    import utc_lt_pkg::*;

    logic [OffsetW-1:0]   offset_reg;
    offset_split_t        split_reg;
    offset_split_t        split_next;
    logic                 wr_en;
    logic                 reg_sel;
    logic [OffsetW-1:0]   wval;
    logic                 wneg;
    logic [OffsetW-1:0]   mag;
    logic [2*OffsetW-1:0] prod;
    logic [OffHourW-1:0]  q;
    logic [OffsetW-1:0]   rem;
    logic [MinuteW-1:0]   r;

    assign reg_sel = (paddr[CfgAddrW-1] == RegOffsetIdx);
    assign wr_en   = psel && penable && pwrite && reg_sel;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(CfgDataW-OffsetW){offset_reg[OffsetW-1]}}, offset_reg} : '0;
    assign split   = split_reg;

    // |offset| / 60 by reciprocal: 1093/65536 is exact for magnitudes up to 1024
    always_comb
    begin
        wval = pwdata[OffsetW-1:0];
        wneg = wval[OffsetW-1];
        mag  = wneg ? (~wval + 11'd1) : wval;
        prod = {{OffsetW{1'b0}}, mag} * 22'd1093;
        q    = prod[2*OffsetW-1:16];
        rem  = mag - ({5'd0, q} * {3'd0, MinPerHour});
        r    = rem[MinuteW-1:0];
        split_next.off_hour = wneg ? (~q + 6'd1) : q;
        split_next.off_min  = wneg ? (~{1'b0, r} + 7'd1) : {1'b0, r};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            split_reg  <= '0;
        end
        else if (wr_en)
        begin
            offset_reg <= wval;
            split_reg  <= split_next;
        end
    end

endmodule

// ===== design/utc_lt_conv.sv =====
// Combinational conversion: minute carry, hour carry and one-day calendar rollover.
module utc_lt_conv (
    input  utc_lt_pkg::utc_time_t     utc,
    input  utc_lt_pkg::offset_split_t split,
    output utc_lt_pkg::local_time_t   loc
);
    import utc_lt_pkg::*;

    logic [7:0]          min_sum;
    logic                min_neg;
    logic                min_ovf;
    logic [7:0]          hour_carry;
    logic [7:0]          hour_sum;
    logic                back;
    logic                fwd;
    logic                leap;
    logic                day_low;
    logic                mon_low;
    logic [MonthW-1:0]   mon_b;
    logic [DayW-1:0]     dim_b;
    logic [DayW-1:0]     dim_f;
    logic [DayW:0]       day_p1;
    logic                roll;
    logic [MonthW:0]     mon_p1;
    logic                year_up;

    always_comb
    begin
        min_sum = {2'b00, utc.utc_minute} + {split.off_min[OffMinW-1], split.off_min};
        min_neg = min_sum[7];
        min_ovf = !min_neg && (min_sum >= MinPerHour);

        if (min_neg)
            hour_carry = 8'hFF;
        else if (min_ovf)
            hour_carry = 8'h01;
        else
            hour_carry = 8'h00;

        hour_sum = {3'b000, utc.utc_hour} + hour_carry
                 + {{2{split.off_hour[OffHourW-1]}}, split.off_hour};
        back = hour_sum[7];
        fwd  = !back && (hour_sum >= HoursPerDay);

        // Feb is only ever looked up in the input's own year
        leap = is_leap(utc.utc_year);

        day_low = (utc.utc_day <= 5'd1);
        mon_low = (utc.utc_month <= 4'd1);
        mon_b   = mon_low ? (utc.utc_month + 4'd11) : (utc.utc_month - 4'd1);
        dim_b   = days_in_month(mon_b, leap);

        dim_f   = days_in_month(utc.utc_month, leap);
        day_p1  = {1'b0, utc.utc_day} + 6'd1;
        roll    = (day_p1 > {1'b0, dim_f});
        mon_p1  = {1'b0, utc.utc_month} + 5'd1;
        year_up = roll && (mon_p1 > MonthsPerYear);

        loc.local_second = utc.utc_second;
        if (min_neg)
            loc.local_minute = 6'(min_sum + MinPerHour);
        else if (min_ovf)
            loc.local_minute = 6'(min_sum - MinPerHour);
        else
            loc.local_minute = min_sum[MinuteW-1:0];

        priority if (back)
        begin
            loc.local_hour    = 5'(hour_sum + HoursPerDay);
            loc.local_weekday = (utc.utc_weekday == 3'd0) ? (DaysPerWeek - 3'd1)
                                                          : (utc.utc_weekday - 3'd1);
            if (day_low)
            begin
                loc.local_day   = utc.utc_day + dim_b - 5'd1;
                loc.local_month = mon_b;
                loc.local_year  = mon_low ? (utc.utc_year - 14'd1) : utc.utc_year;
            end
            else
            begin
                loc.local_day   = utc.utc_day - 5'd1;
                loc.local_month = utc.utc_month;
                loc.local_year  = utc.utc_year;
            end
        end
        else if (fwd)
        begin
            loc.local_hour    = 5'(hour_sum - HoursPerDay);
            // a weekday of 6 or 7 wraps past the end of the week
            loc.local_weekday = (utc.utc_weekday >= DaysPerWeek - 3'd1)
                              ? (utc.utc_weekday - 3'd6) : (utc.utc_weekday + 3'd1);
            if (roll)
            begin
                loc.local_day   = 5'd1;
                loc.local_month = year_up ? 4'(mon_p1 - MonthsPerYear) : mon_p1[MonthW-1:0];
                loc.local_year  = year_up ? (utc.utc_year + 14'd1) : utc.utc_year;
            end
            else
            begin
                loc.local_day   = day_p1[DayW-1:0];
                loc.local_month = utc.utc_month;
                loc.local_year  = utc.utc_year;
            end
        end
        else
        begin
            loc.local_hour    = hour_sum[HourW-1:0];
            loc.local_weekday = utc.utc_weekday;
            loc.local_day     = utc.utc_day;
            loc.local_month   = utc.utc_month;
            loc.local_year    = utc.utc_year;
        end
    end

endmodule

// ===== design/utc_to_local_time_converter_unit.sv =====
// Top level of the UTC to local time converter: request and result registers.
// A request is taken on any cycle with start high; busy is always low, so one time stamp
// can enter every clock. Each request is captured in the request register, converted by
// the calendar arithmetic and captured in the result register, where it is flagged by
// done for exactly one cycle; the receiver has no way to hold it off. The zone offset is
// written over the APB port in minutes (two's complement, 11 bits, at address 0) and is
// split into hours and minutes as it is written; write it only while no request is in
// flight.
module utc_to_local_time_converter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  utc_lt_pkg::utc_time_t              request,
    output logic                               done,
    output utc_lt_pkg::local_time_t            result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [utc_lt_pkg::CfgAddrW-1:0]    paddr,
    input  logic [utc_lt_pkg::CfgDataW-1:0]    pwdata,
    output logic [utc_lt_pkg::CfgDataW-1:0]    prdata,
    output logic                               pready
);
    import utc_lt_pkg::*;

    offset_split_t split;
    utc_time_t     in_reg;
    logic          in_valid_reg;
    local_time_t   conv_out;
    local_time_t   result_reg;
    logic          done_reg;
    logic          accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    utc_lt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .split   (split)
    );

    utc_lt_conv u_conv (
        .utc   (in_reg),
        .split (split),
        .loc   (conv_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= request;
        if (in_valid_reg)
            result_reg <= conv_out;
    end

endmodule

// ===== design/utc_lt_checker.sv =====
// Port-level checker for the converter, bound to the top level.
module utc_lt_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input utc_lt_pkg::utc_time_t              request,
    input logic                               done,
    input utc_lt_pkg::local_time_t            result,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic [utc_lt_pkg::CfgAddrW-1:0]    paddr,
    input logic [utc_lt_pkg::CfgDataW-1:0]    pwdata,
    input logic [utc_lt_pkg::CfgDataW-1:0]    prdata,
    input logic                               pready
);
    import utc_lt_pkg::*;

    // every accepted request yields its result, flagged by done
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted request produced no result");

    // no result without an accepted request before it
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a request");

    a_second_pass: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.local_second == $past(request.utc_second, 2)))
        else $error("second field altered");

    a_offset_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[CfgAddrW-1] == RegOffsetIdx))
        |=> (paddr[CfgAddrW-1] != RegOffsetIdx)
            || (prdata[OffsetW-1:0] == $past(pwdata[OffsetW-1:0])))
        else $error("offset register readback mismatch");

endmodule

bind utc_to_local_time_converter_unit utc_lt_checker u_chk (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the UTC to local time converter: random bursts, APB offset phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utc_lt_pkg::*;

    localparam int IdleLimit = 2000;
    localparam int RandPhases = 12;
    localparam int ItemsPerPhase = 130;
    localparam logic [CfgAddrW-1:0] OffsetAddr = CfgAddrW'(4 * int'(RegOffsetIdx));

    // expected local times in request order, plus the zone offset they are computed with
    class zone_scoreboard;
        int offset_min;
        local_time_t pending_local[$];
        int errors;

        function new();
            offset_min = 0;
            errors = 0;
        endfunction

        function void set_offset(logic [OffsetW-1:0] raw);
            offset_min = int'($signed(raw));
        endfunction

        static function bit leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        static function int month_days(int mon, int unsigned y);
            int lens[12];
            lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            if (mon < 1 || mon > int'(MonthsPerYear))
                return 31;
            if (mon == 2 && leap_year(y & 32'h3FFF))
                return 29;
            return lens[mon - 1];
        endfunction

        function local_time_t shift_to_zone(utc_time_t u);
            int unsigned yr;
            int mon, day, wd, hr, mi;
            int off_h, off_m;
            local_time_t r;
            yr = u.utc_year;
            mon = u.utc_month;
            day = u.utc_day;
            wd = u.utc_weekday;
            hr = u.utc_hour;
            mi = u.utc_minute;
            // both parts truncate toward zero and keep the offset's sign
            off_h = offset_min / int'(MinPerHour);
            off_m = offset_min - off_h * int'(MinPerHour);
            mi += off_m;
            if (mi < 0) begin
                hr--;
                mi += int'(MinPerHour);
            end else if (mi >= int'(MinPerHour)) begin
                hr++;
                mi -= int'(MinPerHour);
            end
            hr += off_h;
            if (hr < 0) begin
                wd--;
                if (wd < 0)
                    wd += int'(DaysPerWeek);
                day--;
                if (day <= 0) begin
                    mon--;
                    if (mon <= 0) begin
                        yr = (yr - 1) & 32'h3FFF;
                        mon += int'(MonthsPerYear);
                    end
                    day += month_days(mon, yr);
                end
                hr += int'(HoursPerDay);
            end else if (hr >= int'(HoursPerDay)) begin
                wd++;
                if (wd >= int'(DaysPerWeek))
                    wd -= int'(DaysPerWeek);
                day++;
                if (day > month_days(mon, yr)) begin
                    mon++;
                    if (mon > int'(MonthsPerYear)) begin
                        yr = (yr + 1) & 32'h3FFF;
                        mon -= int'(MonthsPerYear);
                    end
                    day = 1;
                end
                hr -= int'(HoursPerDay);
            end
            r.local_year = yr[YearW-1:0];
            r.local_month = mon[MonthW-1:0];
            r.local_day = day[DayW-1:0];
            r.local_weekday = wd[WeekdayW-1:0];
            r.local_hour = hr[HourW-1:0];
            r.local_minute = mi[MinuteW-1:0];
            r.local_second = u.utc_second;
            return r;
        endfunction

        function void note_stamp(utc_time_t u);
            pending_local.push_back(shift_to_zone(u));
        endfunction

        static function string stamp_str(local_time_t t);
            return $sformatf("%0d-%0d-%0d wd%0d %0d:%0d:%0d", t.local_year, t.local_month,
                             t.local_day, t.local_weekday, t.local_hour, t.local_minute,
                             t.local_second);
        endfunction

        function void check_local(local_time_t got);
            local_time_t want;
            bit bad;
            if (pending_local.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%t: result with no request pending: %s", $realtime,
                             stamp_str(got));
                return;
            end
            want = pending_local.pop_front();
            bad = (got.local_year !== want.local_year) || (got.local_month !== want.local_month)
                || (got.local_day !== want.local_day)
                || (got.local_weekday !== want.local_weekday)
                || (got.local_hour !== want.local_hour)
                || (got.local_minute !== want.local_minute)
                || (got.local_second !== want.local_second);
            if (bad) begin
                errors++;
                if (errors <= 10)
                    $display("%t: mismatch (offset %0d): expected %s, got %s", $realtime,
                             offset_min, stamp_str(want), stamp_str(got));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    utc_time_t request = '0;
    logic done;
    local_time_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CfgAddrW-1:0] paddr = '0;
    logic [CfgDataW-1:0] pwdata = '0;
    logic [CfgDataW-1:0] prdata;
    logic pready;

    zone_scoreboard board = new();
    int idle_cycles = 0;

    utc_to_local_time_converter_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            board.check_local(result);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done === 1'b1)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("%t: watchdog expired", $realtime);
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic utc_time_t mk(int y, int m, int d, int w, int h, int mi, int s);
        utc_time_t u;
        u.utc_year = y[YearW-1:0];
        u.utc_month = m[MonthW-1:0];
        u.utc_day = d[DayW-1:0];
        u.utc_weekday = w[WeekdayW-1:0];
        u.utc_hour = h[HourW-1:0];
        u.utc_minute = mi[MinuteW-1:0];
        u.utc_second = s[SecondW-1:0];
        return u;
    endfunction

    // mostly legal dates with days, hours and minutes pushed toward the rollover edges
    function automatic utc_time_t random_stamp();
        int y, m, d, h, mi;
        case ($urandom_range(0, 9))
            0: y = 0;
            1: y = 16383;
            2: y = 400 * $urandom_range(0, 24);
            3: y = 100 * $urandom_range(0, 99);
            4: y = 4 * $urandom_range(0, 2499);
            default: y = $urandom_range(0, 9999);
        endcase
        m = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
            0: d = 1;
            1: d = zone_scoreboard::month_days(m, y);
            default: d = $urandom_range(1, zone_scoreboard::month_days(m, y));
        endcase
        case ($urandom_range(0, 3))
            0: h = $urandom_range(0, 3);
            1: h = $urandom_range(20, 23);
            default: h = $urandom_range(0, 23);
        endcase
        case ($urandom_range(0, 3))
            0: mi = $urandom_range(0, 2);
            1: mi = $urandom_range(57, 59);
            default: mi = $urandom_range(0, 59);
        endcase
        return mk(y, m, d, $urandom_range(0, 6), h, mi, $urandom_range(0, 60));
    endfunction

    task automatic push_stamps(utc_time_t stamps[$]);
        int idx, burst, gap;
        idx = 0;
        while (idx < stamps.size()) begin
            burst = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            for (int k = 0; k < burst && idx < stamps.size(); k++) begin
                @(negedge clk);
                start = 1'b1;
                request = stamps[idx];
                do
                    @(posedge clk);
                while (busy);
                board.note_stamp(stamps[idx]);
                idx++;
            end
            @(negedge clk);
            start = 1'b0;
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic write_offset(int off);
        while (board.pending_local.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = OffsetAddr;
        pwdata = CfgDataW'(off);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_offset(pwdata[OffsetW-1:0]);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    initial
    begin
        utc_time_t stamps[$];
        int off;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset offset: zero, all ones, top of the legal range
        stamps = '{mk(0, 0, 0, 0, 0, 0, 0), mk(16383, 15, 31, 7, 31, 63, 63),
                   mk(9999, 12, 31, 6, 23, 59, 60)};
        push_stamps(stamps);

        // forward carries: year end, February in plain, leap and century years, wraps
        write_offset(840);
        stamps = '{mk(2023, 12, 31, 0, 10, 0, 5), mk(2023, 2, 28, 2, 12, 30, 0),
                   mk(2024, 2, 28, 3, 12, 0, 0), mk(1900, 2, 28, 3, 12, 0, 0),
                   mk(2000, 2, 29, 2, 15, 0, 0), mk(16383, 12, 31, 1, 20, 0, 0),
                   mk(5, 13, 31, 4, 11, 0, 0), mk(5, 0, 31, 4, 11, 0, 0),
                   mk(2020, 6, 10, 6, 23, 0, 0), mk(2020, 6, 10, 7, 1, 0, 0)};
        push_stamps(stamps);

        // backward carries: year zero, March 1st, month zero, day zero, weekday seven
        write_offset(-720);
        stamps = '{mk(0, 1, 1, 0, 5, 0, 0), mk(2024, 3, 1, 5, 3, 0, 0),
                   mk(1900, 3, 1, 4, 3, 0, 0), mk(77, 0, 1, 2, 0, 0, 0),
                   mk(300, 5, 0, 3, 3, 0, 0), mk(300, 5, 9, 7, 3, 0, 0)};
        push_stamps(stamps);

        // offsets past the intended range, with minute carries both ways
        write_offset(1023);
        stamps = '{mk(1999, 12, 31, 5, 10, 59, 0)};
        push_stamps(stamps);
        write_offset(-1024);
        stamps = '{mk(2001, 1, 1, 1, 20, 0, 0)};
        push_stamps(stamps);

        for (int p = 0; p < RandPhases; p++) begin
            case (p)
                0: off = 840;
                1: off = -720;
                2: off = 1023;
                3: off = -1024;
                4: off = 1;
                5: off = -1;
                6: off = 330;
                7: off = -570;
                8: off = 0;
                9: off = $urandom_range(0, 2047) - 1024;
                default: off = $urandom_range(0, 1560) - 720;
            endcase
            write_offset(off);
            stamps.delete();
            for (int i = 0; i < ItemsPerPhase; i++) begin
                if ($urandom_range(0, 99) < 85)
                    stamps.push_back(random_stamp());
                else
                    stamps.push_back(utc_time_t'({$urandom, $urandom}));
            end
            push_stamps(stamps);
        end

        while (board.pending_local.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
